// ===== sv/swa_pkg.sv =====
`timescale 1ns / 1ps
package swa_pkg;
	localparam int WHEEL_COUNT_DEF = 4;
	localparam int FRAC_BITS_DEF = 14;
	localparam int GUARD_BITS = 4;
	localparam int CORDIC_STEPS = 14;
	localparam int STEP_W = 4;
	localparam int KINV = 636751;
	localparam int KINV_BITS = 20;
	localparam int REG_COUNT = 8;
	localparam int REG_IDX_W = 3;
	// working width of the CORDIC datapath
	localparam int CW = 26;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT_INIT,
		ST_ROT_STEP,
		ST_ROT_SCALE,
		ST_WHL_INIT,
		ST_VEC_STEP,
		ST_VEC_SCALE,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic rot_init;
		logic rot_step;
		logic rot_scale;
		logic whl_init;
		logic vec_step;
		logic vec_scale;
		logic div_init;
		logic div_step;
		logic [1:0] wheel;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic all_zero;
	} status_t;

	function automatic logic [15:0] atan_bam(input logic [STEP_W-1:0] i);
		logic [15:0] r;
		begin
			case (i)
				4'd0: r = 16'd8192;
				4'd1: r = 16'd4836;
				4'd2: r = 16'd2555;
				4'd3: r = 16'd1297;
				4'd4: r = 16'd651;
				4'd5: r = 16'd326;
				4'd6: r = 16'd163;
				4'd7: r = 16'd81;
				4'd8: r = 16'd41;
				4'd9: r = 16'd20;
				4'd10: r = 16'd10;
				4'd11: r = 16'd5;
				4'd12: r = 16'd3;
				4'd13: r = 16'd1;
				default: r = 16'd0;
			endcase
			return r;
		end
	endfunction
endpackage

// ===== sv/swa_datapath.sv =====
`timescale 1ns / 1ps
module swa_datapath #(
	parameter int FRAC_BITS = swa_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [swa_pkg::REG_IDX_W:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic in_take,
	input  logic [63:0] in_bits,
	input  swa_pkg::cmd_t cmd,
	output swa_pkg::status_t status,
	output logic [14:0] speed,
	output logic [15:0] angle
);
	localparam int CW = swa_pkg::CW;
	localparam int SH = swa_pkg::KINV_BITS + swa_pkg::GUARD_BITS;
	localparam int NUM_W = 17 + FRAC_BITS;

	logic signed [15:0] mult_q [swa_pkg::REG_COUNT];
	logic signed [15:0] vx_q, vy_q, turn_q;
	logic [15:0] head_q;
	logic signed [CW-1:0] x_q, y_q;
	logic signed [17:0] z_q;
	logic signed [17:0] rx_q, ry_q;
	logic [15:0] raw_q [4];
	logic [15:0] ang_q [4];
	logic [15:0] peak_q;
	logic [NUM_W-1:0] quo_q;
	logic [NUM_W:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [15:0] angle_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < swa_pkg::REG_COUNT; i++) mult_q[i] <= '0;
		end else if (cfg_we && !cfg_index[swa_pkg::REG_IDX_W]) begin
			mult_q[cfg_index[swa_pkg::REG_IDX_W-1:0]] <= cfg_data;
		end
	end

	// shared CORDIC step terms
	logic signed [CW-1:0] dx, dy;
	logic signed [17:0] at;
	assign dx = y_q >>> cmd.step;
	assign dy = x_q >>> cmd.step;
	assign at = 18'(signed'({2'b00, swa_pkg::atan_bam(cmd.step)}));

	// heading split
	logic [1:0] quad;
	logic [15:0] zres;
	logic signed [CW-1:0] gx, gy;
	assign quad = 2'((17'(head_q) + 17'd8192) >> 14);
	assign zres = head_q - {quad, 14'd0};
	assign gx = CW'(vx_q) <<< swa_pkg::GUARD_BITS;
	assign gy = CW'(vy_q) <<< swa_pkg::GUARD_BITS;

	// wheel vector before CORDIC
	logic signed [31:0] pmx, pmy;
	logic signed [17:0] px, py;
	assign pmx = mult_q[{cmd.wheel, 1'b0}] * turn_q + (32'sd1 <<< (FRAC_BITS - 1));
	assign pmy = mult_q[{cmd.wheel, 1'b1}] * turn_q + (32'sd1 <<< (FRAC_BITS - 1));
	assign px = rx_q + 18'(pmx >>> FRAC_BITS);
	assign py = ry_q + 18'(pmy >>> FRAC_BITS);

	// scale by KINV
	logic signed [CW+21:0] kx, ky;
	logic signed [CW+21:0] rnd;
	assign rnd = (CW+22)'(1) <<< (SH - 1);
	assign kx = ((CW+22)'(x_q) * (CW+22)'(swa_pkg::KINV) + rnd) >>> SH;
	assign ky = ((CW+22)'(y_q) * (CW+22)'(swa_pkg::KINV) + rnd) >>> SH;

	// restoring division trial
	logic [NUM_W:0] trial;
	assign trial = {rem_q[NUM_W-1:0], num_q[NUM_W-1]};

	always_ff @(posedge clk) begin
		if (in_take) begin
			vx_q <= in_bits[15:0];
			vy_q <= in_bits[31:16];
			turn_q <= in_bits[47:32];
			head_q <= in_bits[63:48];
		end
		if (cmd.rot_init) begin
			unique case (quad)
				2'd0: begin x_q <= gx; y_q <= gy; end
				2'd1: begin x_q <= -gy; y_q <= gx; end
				2'd2: begin x_q <= -gx; y_q <= -gy; end
				default: begin x_q <= gy; y_q <= -gx; end
			endcase
			z_q <= 18'(signed'(zres));
		end
		if (cmd.rot_step) begin
			if (!z_q[17]) begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
			end
		end
		if (cmd.rot_scale) begin
			rx_q <= 18'(kx);
			ry_q <= 18'(ky);
		end
		// vectoring runs on (a, b) = (y, x) held in x_q, y_q
		if (cmd.whl_init) begin
			if (py[17]) begin
				x_q <= -(CW'(py) <<< swa_pkg::GUARD_BITS);
				y_q <= -(CW'(px) <<< swa_pkg::GUARD_BITS);
				z_q <= 18'sd32768;
			end else begin
				x_q <= CW'(py) <<< swa_pkg::GUARD_BITS;
				y_q <= CW'(px) <<< swa_pkg::GUARD_BITS;
				z_q <= '0;
			end
			if (cmd.wheel == 2'd0) peak_q <= '0;
		end
		if (cmd.vec_step) begin
			if (!y_q[CW-1]) begin
				x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
			end else begin
				x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
			end
		end
		if (cmd.vec_scale) begin
			logic [15:0] m;
			logic zv;
			// only a zero vector ends with both terms at zero: drop its angle
			zv = (x_q == 0 && y_q == 0);
			m = kx[CW+21] ? 16'd0 : (kx > 65535 ? 16'hFFFF : 16'(kx));
			if (zv) m = '0;
			raw_q[cmd.wheel] <= m;
			ang_q[cmd.wheel] <= zv ? 16'd0 : 16'(z_q);
			if (m > peak_q) peak_q <= m;
		end
		if (cmd.div_init) begin
			num_q <= NUM_W'({raw_q[cmd.wheel], {FRAC_BITS{1'b0}}}) + NUM_W'(peak_q >> 1);
			rem_q <= '0;
			quo_q <= '0;
			angle_q <= ang_q[cmd.wheel];
		end
		if (cmd.div_step) begin
			num_q <= num_q << 1;
			if (trial >= (NUM_W+1)'(peak_q)) begin
				rem_q <= trial - (NUM_W+1)'(peak_q);
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign status.all_zero = (peak_q == 16'd0);
	assign speed = status.all_zero ? 15'd0 :
		(quo_q > NUM_W'(32767) ? 15'h7FFF : 15'(quo_q));
	assign angle = angle_q;
endmodule

// ===== sv/swa_ctrl.sv =====
`timescale 1ns / 1ps
module swa_ctrl #(
	parameter int WHEEL_COUNT = swa_pkg::WHEEL_COUNT_DEF,
	parameter int FRAC_BITS = swa_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic [1:0] out_wheel,
	output logic out_last,
	output swa_pkg::cmd_t cmd
);
	localparam int DIV_STEPS = 17 + FRAC_BITS;
	localparam int CNT_W = $clog2(DIV_STEPS + 1);
	localparam logic [1:0] LAST_W = 2'(WHEEL_COUNT - 1);

	swa_pkg::state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [1:0] wheel_q, wheel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swa_pkg::ST_IDLE;
			cnt_q <= '0;
			wheel_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			wheel_q <= wheel_d;
		end
	end

	// sequence rotation, per-wheel vectoring, then division and emit
	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		wheel_d = wheel_q;
		cmd = '0;
		cmd.wheel = wheel_q;
		cmd.step = cnt_q[swa_pkg::STEP_W-1:0];
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			swa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = swa_pkg::ST_ROT_INIT;
			end
			swa_pkg::ST_ROT_INIT: begin
				cmd.rot_init = 1'b1;
				cnt_d = '0;
				state_d = swa_pkg::ST_ROT_STEP;
			end
			swa_pkg::ST_ROT_STEP: begin
				cmd.rot_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(swa_pkg::CORDIC_STEPS - 1))
					state_d = swa_pkg::ST_ROT_SCALE;
			end
			swa_pkg::ST_ROT_SCALE: begin
				cmd.rot_scale = 1'b1;
				wheel_d = '0;
				state_d = swa_pkg::ST_WHL_INIT;
			end
			swa_pkg::ST_WHL_INIT: begin
				cmd.whl_init = 1'b1;
				cnt_d = '0;
				state_d = swa_pkg::ST_VEC_STEP;
			end
			swa_pkg::ST_VEC_STEP: begin
				cmd.vec_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(swa_pkg::CORDIC_STEPS - 1))
					state_d = swa_pkg::ST_VEC_SCALE;
			end
			swa_pkg::ST_VEC_SCALE: begin
				cmd.vec_scale = 1'b1;
				if (wheel_q == LAST_W) begin
					wheel_d = '0;
					state_d = swa_pkg::ST_DIV_INIT;
				end else begin
					wheel_d = wheel_q + 1'b1;
					state_d = swa_pkg::ST_WHL_INIT;
				end
			end
			swa_pkg::ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cnt_d = '0;
				state_d = swa_pkg::ST_DIV_STEP;
			end
			swa_pkg::ST_DIV_STEP: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = swa_pkg::ST_EMIT;
			end
			swa_pkg::ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (wheel_q == LAST_W) begin
						state_d = swa_pkg::ST_IDLE;
					end else begin
						wheel_d = wheel_q + 1'b1;
						state_d = swa_pkg::ST_DIV_INIT;
					end
				end
			end
			default: state_d = swa_pkg::ST_IDLE;
		endcase
	end

	assign out_wheel = wheel_q;
	assign out_last = (wheel_q == LAST_W);

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while emitting");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == swa_pkg::ST_ROT_INIT)
		else $error("request not started");
	a_wheel_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> wheel_q <= LAST_W) else $error("wheel out of range");
endmodule

// ===== sv/swerve_wheel_speed_angle_unit.sv =====
`timescale 1ns / 1ps
// Swerve wheel speed/angle unit: one command in (velocity, turn rate,
// heading), WHEEL_COUNT results out (speed normalized to the fastest wheel,
// atan2 steering angle). A request runs one CORDIC rotation, then one CORDIC
// vectoring per wheel, then a restoring division per wheel before each result
// is emitted, on one shared CORDIC unit and one shared bit-serial divider.
// An output stall holds the unit in its emit state. One request at a time.
module swerve_wheel_speed_angle_unit #(
	parameter int WHEEL_COUNT = swa_pkg::WHEEL_COUNT_DEF,
	parameter int FRAC_BITS = swa_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [swa_pkg::REG_IDX_W:0] cfg_index,
	input  logic [15:0] cfg_data,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [63:0] s_tdata,   // vel_x, vel_y, turn_rate, heading
	output logic m_tvalid,
	input  logic m_tready,
	output logic [39:0] m_tdata,   // wheel_index, wheel_speed, wheel_angle, zero pad
	output logic m_tuser,          // all_zero
	output logic m_tlast
);
	swa_pkg::cmd_t cmd;
	swa_pkg::status_t status;
	logic [14:0] speed;
	logic [15:0] angle;
	logic [1:0] wheel;

	swa_ctrl #(.WHEEL_COUNT(WHEEL_COUNT), .FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_wheel(wheel),
		.out_last(m_tlast), .cmd
	);

	swa_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_take(s_tvalid && s_tready), .in_bits(s_tdata),
		.cmd, .status, .speed, .angle
	);

	assign m_tdata = {7'd0, angle, speed, wheel};
	assign m_tuser = status.all_zero;
endmodule
